>>> rtl/wrapped_moving_average_core_macros.svh
// assertion macros for the wrapped moving average core
// expects clk and rst in the scope of the module that uses them
`ifndef WRAPPED_MOVING_AVERAGE_CORE_MACROS_SVH
`define WRAPPED_MOVING_AVERAGE_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define WMA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define WMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/wma_pkg.sv
// shared types and widths for the wrapped moving average core
// no dependencies
package wma_pkg;

  localparam int SAMPLE_W = 32;  // q16.16 sample and result
  localparam int CUT_W    = 31;  // q15.16 wrap period, unsigned

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CUT_W-1:0]           cut_t;

endpackage

>>> rtl/wma_if.sv
// valid/ready channel interfaces for the wrapped moving average core
// depends on wma_pkg
interface wma_sample_if import wma_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface wma_smoothed_if import wma_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t smoothed;
  modport source (output valid, output smoothed, input ready);
  modport sink (input valid, input smoothed, output ready);
endinterface

interface wma_cfg_if import wma_pkg::*; ();
  logic valid;
  logic ready;
  cut_t branch_cut;
  modport source (output valid, output branch_cut, input ready);
  modport sink (input valid, input branch_cut, output ready);
endinterface

>>> rtl/wrapped_moving_average_core.sv
// wrapped moving average core, top level
// depends on wma_pkg, wma_if.sv and wrapped_moving_average_core_macros.svh
//
// Takes one q16.16 sample word at a time and returns the mean of the last
// WINDOW_LEN samples, truncated toward zero and saturated to 32 bits. With a
// nonzero branch_cut the window is unwrapped first: walking from slot 0,
// any entry more than half a cut away from the previous unwrapped value is
// moved by one cut towards it (exactly half a cut is left alone). The very
// first sample after reset fills the whole window and comes straight back.
// Every later sample is written into the ring, then one shared
// subtract/compare datapath walks the window one entry per cycle from a
// single-port memory with registered read, through the read register and
// the unwrap register into the sum. The divide by WINDOW_LEN is a shift for
// a power-of-two window and otherwise, after a set-up step, a multiply by a
// fixed reciprocal, one 16-bit slice of the dividend per cycle. The result
// is then saturated and handed off. The input is taken only while the core
// is idle; a finished result waits in the output register, so the next
// sample may be taken before it is collected.
// branch_cut is always ready and should only be written between samples.
`include "wrapped_moving_average_core_macros.svh"

module wrapped_moving_average_core import wma_pkg::*; #(
  parameter int WINDOW_LEN = 8
) (
  input  logic            clk,
  input  logic            rst,
  wma_sample_if.sink      sample_ch,
  wma_smoothed_if.source  smoothed_ch,
  wma_cfg_if.sink         cfg_ch
);

  // address, count and sum widths
  localparam int AW    = $clog2(WINDOW_LEN);
  localparam int CW    = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W = 33 + $clog2(WINDOW_LEN);
  localparam int DCW   = $clog2(SUM_W + 1);
  localparam bit POW2  = (WINDOW_LEN & (WINDOW_LEN - 1)) == 0;

  // reciprocal divide: 16-bit dividend slices, exact for any sum magnitude
  localparam int NCH    = (SUM_W + 15) / 16;
  localparam int SH     = (SUM_W + AW > 16 * NCH) ? SUM_W + AW : 16 * NCH;
  localparam int SH_FIX = SH - 16 * NCH;
  localparam int MW     = SH + 1;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(WINDOW_LEN - 1)) / 64'(WINDOW_LEN));

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_DIVP = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SAT  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state;

  // window ring and its bookkeeping
  sample_t       mem [WINDOW_LEN];
  sample_t       mem_q;
  logic [AW-1:0] write_slot;
  logic [CW-1:0] filled;        // slots written since reset
  logic          first_pending;
  sample_t       first_val;     // value of every slot not yet written
  cut_t          branch_cut;

  // walk pipeline
  logic [CW-1:0]             rd_idx;
  logic                      issue;
  logic                      v1, first1, last1, fill1;
  logic                      v2, last2;
  logic signed [32:0]        prev_q;
  logic signed [SUM_W-1:0]   total;

  // divider and result
  logic                  neg;
  logic [SUM_W-1:0]      dq;          // dividend in, quotient out
  logic [MW-1:0]         acc;         // reciprocal product, shifted down per slice
  logic [MW+15:0]        prod_sum;
  logic [DCW-1:0]        dcnt;
  logic [SUM_W-1:0]      mag;
  sample_t               mean_res;
  sample_t               sat_val;

  // unwrap datapath signals
  sample_t               e;
  logic signed [32:0]    e33;
  logic signed [32:0]    cut33;
  logic signed [33:0]    diff;
  logic signed [34:0]    d2;
  logic signed [34:0]    cut35;
  logic                  over, under;
  logic signed [32:0]    prev_sel;

  logic accept;
  logic out_free;

  assign accept   = sample_ch.valid && sample_ch.ready;
  assign out_free = !smoothed_ch.valid || smoothed_ch.ready;
  assign sample_ch.ready = (state == S_IDLE);
  assign cfg_ch.ready    = 1'b1;
  assign issue = (state == S_WALK) && (rd_idx < CW'(WINDOW_LEN));

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      branch_cut <= '0;
    end else if (cfg_ch.valid) begin
      branch_cut <= cfg_ch.branch_cut;
    end
  end

  // window memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[write_slot] <= sample_ch.sample;
    end
    if (issue) begin
      mem_q <= mem[rd_idx[AW-1:0]];
    end
  end

  // unwrap step: slots never written read as the first sample
  always_comb begin
    e     = fill1 ? mem_q : first_val;
    e33   = {e[31], e};
    cut33 = {2'b00, branch_cut};
    cut35 = {4'b0000, branch_cut};
    diff  = {e33[32], e33} - {prev_q[32], prev_q};
    d2    = {diff, 1'b0};
    over  = d2 > cut35;
    under = d2 < -cut35;
    if (first1) begin
      prev_sel = e33;
    end else if (over) begin
      prev_sel = e33 - cut33;
    end else if (under) begin
      prev_sel = e33 + cut33;
    end else begin
      prev_sel = e33;
    end
  end

  // magnitude for the divider, and one reciprocal slice step
  always_comb begin
    mag      = total[SUM_W-1] ? SUM_W'(-total) : SUM_W'(total);
    prod_sum = (MW+16)'(acc) + (MW+16)'(RECIP) * (MW+16)'(dq[15:0]);
  end

  // clamp the quotient back to 32 bits with the sign restored
  always_comb begin
    if (neg) begin
      if ((dq[SUM_W-1:32] != '0) || (dq[31] && (dq[30:0] != '0))) begin
        sat_val = 32'sh8000_0000;
      end else begin
        sat_val = -$signed(dq[31:0]);
      end
    end else begin
      if (dq[SUM_W-1:31] != '0) begin
        sat_val = 32'sh7fff_ffff;
      end else begin
        sat_val = $signed(dq[31:0]);
      end
    end
  end

  // walk pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
    first1 <= issue && (rd_idx == '0);
    last1  <= issue && (rd_idx == CW'(WINDOW_LEN - 1));
    fill1  <= rd_idx < filled;
    last2  <= v1 && last1;
    if (v1) begin
      prev_q <= prev_sel;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      write_slot        <= '0;
      filled            <= '0;
      first_pending     <= 1'b1;
      smoothed_ch.valid <= 1'b0;
    end else begin
      // a new word replaces one taken in the same cycle
      if (state == S_EMIT && out_free) begin
        smoothed_ch.valid <= 1'b1;
      end else if (smoothed_ch.valid && smoothed_ch.ready) begin
        smoothed_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            write_slot <= (write_slot == AW'(WINDOW_LEN - 1)) ? '0 : write_slot + 1'b1;
            if (filled != CW'(WINDOW_LEN)) begin
              filled <= filled + 1'b1;
            end
            if (first_pending) begin
              // first word fills the window, its mean is itself
              first_pending <= 1'b0;
              first_val     <= sample_ch.sample;
              mean_res      <= sample_ch.sample;
              state         <= S_EMIT;
            end else begin
              rd_idx <= '0;
              total  <= '0;
              state  <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (v2) begin
            total <= total + {{(SUM_W-33){prev_q[32]}}, prev_q};
            if (last2) begin
              state <= S_DIVP;
            end
          end
        end
        S_DIVP: begin
          neg <= total[SUM_W-1];
          if (POW2) begin
            dq    <= mag >> AW;
            state <= S_SAT;
          end else begin
            dq    <= mag;
            acc   <= '0;
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // lowest slice first, product kept shifted down by 16 each cycle
          acc  <= prod_sum[MW+15:16];
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCW'(NCH - 1)) begin
            dq    <= SUM_W'(prod_sum[MW+15:16] >> SH_FIX);
            state <= S_SAT;
          end else begin
            dq <= dq >> 16;
          end
        end
        S_SAT: begin
          mean_res <= sat_val;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          // hand over once the output register is free
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      smoothed_ch.smoothed <= mean_res;
    end
  end

  `WMA_ASSERT_NEXT(a_first_direct, accept && first_pending, state == S_EMIT,
                   "first word must skip the walk")
  `WMA_ASSERT_NEXT(a_later_walk, accept && !first_pending, state == S_WALK && rd_idx == '0,
                   "later word must start a walk")
  `WMA_ASSERT_NOW(a_ring_bounds, 1'b1,
                  filled <= CW'(WINDOW_LEN) && write_slot <= AW'(WINDOW_LEN - 1),
                  "ring pointer or fill count out of range")
  `WMA_ASSERT_NEXT(a_walk_end, state == S_WALK && v2 && last2,
                   state == S_DIVP && !v1 && !v2, "walk did not drain before divide")
  `WMA_ASSERT_NEXT(a_emit, state == S_EMIT && out_free,
                   smoothed_ch.valid && state == S_IDLE, "result word not presented")

endmodule

>>> dv/testbench.sv
// self-checking testbench for wrapped_moving_average_core
// depends on wma_pkg, wma_if.sv and the core rtl; predicts every smoothed word
// from its own model of the unwrapped ring mean and compares the whole word
module testbench;
  import wma_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN         = 8;
  localparam int STALL_LIMIT = 4000;   // cycles with no word moving on any channel
  localparam int DRAIN_WAIT  = 20;     // extra wait after the last predicted word is back
  localparam int IDLE_PCT    = 36;

  localparam sample_t MOST_NEG = 32'sh8000_0000;
  localparam sample_t MOST_POS = 32'sh7FFF_FFFF;
  localparam cut_t    CUT_MAX  = 31'h7FFF_FFFF;

  logic clk;
  logic rst;

  wma_sample_if   sample_ch ();
  wma_smoothed_if smoothed_ch ();
  wma_cfg_if      cfg_ch ();

  wrapped_moving_average_core #(.WINDOW_LEN(WIN)) DUT (
    .clk         (clk),
    .rst         (rst),
    .sample_ch   (sample_ch),
    .smoothed_ch (smoothed_ch),
    .cfg_ch      (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------------
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // model of the block: ring of sign-extended entries, write slot, first-fill
  // flag and the cut currently in force
  // ---------------------------------------------------------------------------
  longint ring [WIN];
  int     ring_slot;
  bit     fill_pending;
  cut_t   cut_now;

  sample_t pending_means [$];   // smoothed words predicted but not yet seen
  sample_t expected_mean;
  int      errors;
  int      quiet_cycles;
  bit      calm;                // when set neither side idles
  longint  heading;             // running value for the well-formed random walk

  function automatic sample_t average_next(input sample_t value);
    longint total, prev, diff, cut_l;
    total = 0;
    cut_l = longint'({33'd0, cut_now});
    // first word after reset fills the whole ring and comes straight back
    if (fill_pending) begin
      for (int i = 0; i < WIN; i++) ring[i] = longint'(value);
      ring_slot    = 1 % WIN;
      fill_pending = 1'b0;
      return value;
    end
    ring[ring_slot] = longint'(value);
    ring_slot       = (ring_slot + 1) % WIN;
    if (cut_l != 0) begin
      // walk from slot 0, pulling each entry by one cut towards its neighbour;
      // a gap of exactly half a cut is left alone
      prev  = ring[0];
      total = prev;
      for (int i = 1; i < WIN; i++) begin
        diff = ring[i] - prev;
        if (2 * diff > cut_l) prev = ring[i] - cut_l;
        else if (2 * diff < -cut_l) prev = ring[i] + cut_l;
        else prev = ring[i];
        total += prev;
      end
    end else begin
      for (int i = 0; i < WIN; i++) total += ring[i];
    end
    total = total / WIN;   // truncates toward zero
    if (total > longint'(MOST_POS)) total = longint'(MOST_POS);
    if (total < longint'(MOST_NEG)) total = longint'(MOST_NEG);
    return sample_t'(total);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random back-pressure, compare against oldest prediction,
  // and a watchdog on channel activity
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      smoothed_ch.ready <= 1'b0;
      quiet_cycles = 0;
    end else begin
      smoothed_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (smoothed_ch.valid && smoothed_ch.ready) begin
        if (pending_means.size() == 0) begin
          $display("%0t unexpected smoothed word: expected none actual %0d",
                   $time, smoothed_ch.smoothed);
          errors++;
        end else begin
          expected_mean = pending_means.pop_front();
          if (smoothed_ch.smoothed !== expected_mean) begin
            $display("%0t smoothed mismatch: expected %0d actual %0d",
                     $time, expected_mean, smoothed_ch.smoothed);
            errors++;
          end
        end
      end
      // any word moving on any channel counts as progress
      if ((sample_ch.valid && sample_ch.ready) ||
          (smoothed_ch.valid && smoothed_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t watchdog: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offers one sample word, with a random gap first unless calm; valid is left
  // high after the handshake so back-to-back words follow without a gap
  task automatic send_sample(input sample_t value);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        sample_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= value;
    do @(posedge clk); while (!sample_ch.ready);
    pending_means.push_back(average_next(value));
  endtask

  // drops valid and waits for every predicted word to come back
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_means.size() != 0);
  endtask

  // cut is only changed with the core idle, so it applies to the next sample
  task automatic write_cut(input cut_t value);
    drain_results();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.branch_cut <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cut_now = value;
  endtask

  // stimulus for one random phase: mostly a smooth walk that wraps at the cut,
  // with noise and words sitting right on the half-cut boundary
  function automatic sample_t wrapped_stimulus(input cut_t cut);
    longint period, half, span;
    int     pick;
    period = longint'({33'd0, cut});
    pick   = $urandom_range(99);
    if (pick < 15) return sample_t'($urandom);
    if (period == 0) begin
      heading = heading + longint'($urandom_range(32'h0002_0000)) - 64'sh1_0000;
      heading = longint'(sample_t'(heading));
      return sample_t'(heading);
    end
    half = period / 2;
    // exactly half a cut away, and one step past it, either direction
    if (pick < 20) return sample_t'(heading + half);
    if (pick < 25) return sample_t'(heading - half);
    if (pick < 28) return sample_t'(heading + half + 1);
    if (pick < 31) return sample_t'(heading - half - 1);
    span    = period / 4 + 1;
    heading = heading + longint'($urandom_range(32'(2 * span))) - span;
    if (heading > half) heading -= period;
    if (heading < -half) heading += period;
    return sample_t'(heading);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // first word fills the ring; the chain then drifts below the most negative
  // value and the mean must clamp
  task automatic test_first_fill_and_negative_clamp();
    write_cut(CUT_MAX);
    send_sample(MOST_NEG);
    for (int i = 0; i < WIN - 1; i++) send_sample(-32'sd966367642);
  endtask

  // ring pointer is back at slot 0 here; same drift upwards
  task automatic test_positive_clamp();
    send_sample(MOST_POS);
    for (int i = 0; i < WIN - 1; i++) send_sample(32'sd966367641);
  endtask

  // cut of zero: plain mean over the extremes
  task automatic test_plain_mean_extremes();
    write_cut('0);
    send_sample(MOST_POS);
    send_sample(MOST_POS);
    send_sample(MOST_NEG);
    send_sample(MOST_NEG);
  endtask

  // cut of 2.0: steps of exactly 1.0 stay put, steps just over 1.0 are moved
  task automatic test_exact_half_cut();
    write_cut(31'h0002_0000);
    send_sample(32'sh0000_0000);
    send_sample(32'sh0001_0000);
    send_sample(32'sh0002_0000);
    send_sample(32'sh0003_0001);
    send_sample(32'sh0002_0001);
    send_sample(32'sh0001_0001);
    send_sample(32'sh0000_0000);
    send_sample(-32'sh0001_0000);
  endtask

  // several cut settings, extremes among them, one phase without any idling
  task automatic test_random_phases();
    cut_t phase_cuts [8];
    phase_cuts[0] = '0;
    phase_cuts[1] = CUT_MAX;
    phase_cuts[2] = 31'h0168_0000;              // 360.0
    phase_cuts[3] = 31'h0006_487F;              // two pi
    phase_cuts[4] = 31'd1;
    phase_cuts[5] = 31'd2;
    phase_cuts[6] = cut_t'($urandom);
    phase_cuts[7] = cut_t'($urandom_range(32'h0000_FFFF, 1));
    for (int p = 0; p < 8; p++) begin
      write_cut(phase_cuts[p]);
      calm    = (p == 2);
      heading = 0;
      for (int n = 0; n < 128; n++) send_sample(wrapped_stimulus(phase_cuts[p]));
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    errors       = 0;
    calm         = 1'b0;
    heading      = 0;
    fill_pending = 1'b1;
    ring_slot    = 0;
    cut_now      = '0;
    for (int i = 0; i < WIN; i++) ring[i] = 0;

    rst               <= 1'b1;
    sample_ch.valid   <= 1'b0;
    sample_ch.sample  <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.branch_cut <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_first_fill_and_negative_clamp();
    test_positive_clamp();
    test_plain_mean_extremes();
    test_exact_half_cut();
    test_random_phases();

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/wma_pkg.sv
rtl/wma_if.sv
rtl/wrapped_moving_average_core.sv
dv/testbench.sv
